### hdl/pwb_pkg.sv
package pwb_pkg;

  // Sizes of the source store and of the fixed-point arithmetic
  localparam int SRC_MAX_WIDTH    = 256;
  localparam int SRC_MAX_HEIGHT   = 256;
  localparam int WEIGHT_FRAC_BITS = 8;
  localparam int DEST_COORD_BITS  = 12;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int POS_W     = 12;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int COEF_W    = 32;
  localparam int DIM_W     = 9;
  localparam int MODE_W    = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Mode bits
  localparam int MODE_TRUNC_BIT = 0;
  localparam int MODE_BLEND_BIT = 1;

  // Derived arithmetic widths
  localparam int WF      = WEIGHT_FRAC_BITS;
  localparam int DC      = DEST_COORD_BITS;
  localparam int PROD_W  = DC + 1 + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int IB_X    = $clog2(SRC_MAX_WIDTH);
  localparam int IB_Y    = $clog2(SRC_MAX_HEIGHT);
  localparam int IB      = (IB_X > IB_Y) ? IB_X : IB_Y;
  localparam int QB      = IB + WF;
  localparam int RW      = SUM_W + QB;
  localparam int DIV_LAT = QB + 1;
  localparam int LIM_W   = ((DIM_W > IB + 1) ? DIM_W : IB + 1) + 1;
  localparam int TOP_W   = PIX_W + WF + 1;
  localparam int MIX_W   = PIX_W + 2 * WF + 1;
  localparam int BL_W    = 2 * PIX_W;

  // Source store split into four banks by column and row parity
  localparam int BANK_COLS  = (SRC_MAX_WIDTH + 1) / 2;
  localparam int BANK_ROWS  = (SRC_MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int STORE_W    = 2 * PIX_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0_LIN = 3'd0,
    CFG_ROW1_LIN = 3'd1,
    CFG_ROW2_LIN = 3'd2,
    CFG_SHIFT01  = 3'd3,
    CFG_SHIFT2   = 3'd4,
    CFG_MODE     = 3'd5,
    CFG_SRC_W    = 3'd6,
    CFG_SRC_H    = 3'd7
  } cfg_idx_e;

  // Per-word side data that rides along the pipe
  typedef struct packed {
    logic             cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] alpha;
    logic             bad;
  } side_t;

endpackage

### hdl/pwb_ram.sv
module pwb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pwb_div.sv
// Pipelined restoring divider: q = floor(nm * 2^WF / dm), one quotient bit per stage.
// ovf flags a quotient that does not fit in QB bits.
module pwb_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [pwb_pkg::SUM_W-1:0]      nm_i,
  input  logic [pwb_pkg::SUM_W-1:0]      dm_i,
  output logic [pwb_pkg::QB-1:0]         q_o,
  output logic                           ovf_o
);

  localparam int SW = pwb_pkg::SUM_W;
  localparam int QB = pwb_pkg::QB;
  localparam int RW = pwb_pkg::RW;

  logic [RW-1:0] r_q   [QB+1];
  logic [SW-1:0] d_q   [QB+1];
  logic [QB-1:0] qb_q  [QB+1];
  logic          ovf_q [QB+1];

  // Stage 0: scale the dividend, check the quotient range
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= RW'(nm_i) << pwb_pkg::WF;
      d_q[0]   <= dm_i;
      qb_q[0]  <= '0;
      ovf_q[0] <= (SW + pwb_pkg::IB)'(nm_i) >= ((SW + pwb_pkg::IB)'(dm_i) << pwb_pkg::IB);
    end
  end

  // One quotient bit per stage, MSB first
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int BIT = QB - k;
    logic [RW:0] trial;
    assign trial = {1'b0, r_q[k-1]} - ((RW + 1)'(d_q[k-1]) << BIT);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k]   <= d_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        if (!trial[RW]) begin
          r_q[k]       <= trial[RW-1:0];
          qb_q[k]      <= qb_q[k-1] | (QB'(1) << BIT);
        end else begin
          r_q[k]       <= r_q[k-1];
          qb_q[k]      <= qb_q[k-1];
        end
      end
    end
  end

  assign q_o   = qb_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

### hdl/perspective_warp_bilinear.sv
// Channel | handshake                | payload
// --------+--------------------------+-------------------------------------------
// in      | in_valid_i / in_stall_o  | cmd_i pos_x_i pos_y_i pix_value_i alpha_value_i
// out     | out_valid_o / out_stall_i| out_pixel_o written_o
// cfg     | cfg_we_i                 | cfg_idx_i cfg_wdata_i
//
// One word enters per clock while in_stall_o is low. The two 17-stage quotient dividers make up
// most of the pipe. Load words are written into the four-bank source store at the same stage
// that warp words read it. Reset clears control state and sets configuration to its defaults;
// the store holds garbage until loaded. The whole pipe halts only when the output register
// holds a stalled word and the last stage has a warp word for it; bubbles keep moving otherwise.
module perspective_warp_bilinear (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pwb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pwb_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [pwb_pkg::POS_W-1:0]       pos_x_i,
  input  logic [pwb_pkg::POS_W-1:0]       pos_y_i,
  input  logic [pwb_pkg::PIX_W-1:0]       pix_value_i,
  input  logic [pwb_pkg::PIX_W-1:0]       alpha_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pwb_pkg::PIX_W-1:0]       out_pixel_o,
  output logic                            written_o
);

  localparam int SW   = pwb_pkg::SUM_W;
  localparam int PW   = pwb_pkg::PROD_W;
  localparam int CW   = pwb_pkg::COEF_W;
  localparam int QB   = pwb_pkg::QB;
  localparam int WF   = pwb_pkg::WF;
  localparam int IB   = pwb_pkg::IB;
  localparam int PXW  = pwb_pkg::PIX_W;
  localparam int LW   = pwb_pkg::LIM_W;
  localparam int AW   = pwb_pkg::BANK_AW;
  localparam int NDIV = pwb_pkg::DIV_LAT;

  // ---------------- configuration registers ----------------
  logic [pwb_pkg::CFG_W-1:0]  row0_q, row1_q, row2_q, shift01_q;
  logic [CW-1:0]              shift2_q;
  logic [pwb_pkg::MODE_W-1:0] mode_q;
  logic [pwb_pkg::DIM_W-1:0]  src_w_q, src_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q    <= '0;
      row1_q    <= '0;
      row2_q    <= '0;
      shift01_q <= '0;
      shift2_q  <= CW'(32'h0100_0000);
      mode_q    <= '0;
      src_w_q   <= pwb_pkg::DIM_W'(256);
      src_h_q   <= pwb_pkg::DIM_W'(256);
    end else if (cfg_we_i) begin
      unique case (pwb_pkg::cfg_idx_e'(cfg_idx_i))
        pwb_pkg::CFG_ROW0_LIN: row0_q    <= cfg_wdata_i;
        pwb_pkg::CFG_ROW1_LIN: row1_q    <= cfg_wdata_i;
        pwb_pkg::CFG_ROW2_LIN: row2_q    <= cfg_wdata_i;
        pwb_pkg::CFG_SHIFT01:  shift01_q <= cfg_wdata_i;
        pwb_pkg::CFG_SHIFT2:   shift2_q  <= cfg_wdata_i[CW-1:0];
        pwb_pkg::CFG_MODE:     mode_q    <= cfg_wdata_i[pwb_pkg::MODE_W-1:0];
        pwb_pkg::CFG_SRC_W:    src_w_q   <= cfg_wdata_i[pwb_pkg::DIM_W-1:0];
        pwb_pkg::CFG_SRC_H:    src_h_q   <= cfg_wdata_i[pwb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] h00, h01, h10, h11, h20, h21, h02, h12, h22;
  assign h00 = signed'(row0_q[2*CW-1:CW]);
  assign h01 = signed'(row0_q[CW-1:0]);
  assign h10 = signed'(row1_q[2*CW-1:CW]);
  assign h11 = signed'(row1_q[CW-1:0]);
  assign h20 = signed'(row2_q[2*CW-1:CW]);
  assign h21 = signed'(row2_q[CW-1:0]);
  assign h02 = signed'(shift01_q[2*CW-1:CW]);
  assign h12 = signed'(shift01_q[CW-1:0]);
  assign h22 = signed'(shift2_q);

  logic trunc, blend;
  assign trunc = mode_q[pwb_pkg::MODE_TRUNC_BIT];
  assign blend = mode_q[pwb_pkg::MODE_BLEND_BIT];

  // ---------------- flow control ----------------
  logic en, out_load, last_v;
  logic out_valid_q;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign en         = !last_v || out_load;
  assign in_stall_o = !en;

  // ---------------- valid bits ----------------
  logic v1_q, v2_q, v3_q, v4_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic vd_q [NDIV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      for (int i = 0; i < NDIV; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      vd_q[0] <= v4_q;
      for (int i = 1; i < NDIV; i++) vd_q[i] <= vd_q[i-1];
      v6_q    <= vd_q[NDIV-1];
      v7_q    <= v6_q;
      v8_q    <= v7_q;
      v9_q    <= v8_q;
      v10_q   <= v9_q;
    end
  end

  // ---------------- stage 1: input word ----------------
  pwb_pkg::side_t s1_q, s2_q, s3_q, s4_q;
  pwb_pkg::side_t sd_q [NDIV];
  logic [pwb_pkg::DC-1:0] x1_q, y1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.cmd   <= cmd_i;
      s1_q.pos_x <= pos_x_i;
      s1_q.pos_y <= pos_y_i;
      s1_q.pix   <= pix_value_i;
      s1_q.alpha <= alpha_value_i;
      s1_q.bad   <= 1'b0;
      x1_q       <= pwb_pkg::DC'(pos_x_i);
      y1_q       <= pwb_pkg::DC'(pos_y_i);
    end
  end

  // ---------------- stage 2: six coefficient products ----------------
  logic signed [PW-1:0] m_q [6];
  logic signed [pwb_pkg::DC:0] xs, ys;
  assign xs = signed'({1'b0, x1_q});
  assign ys = signed'({1'b0, y1_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q   <= s1_q;
      m_q[0] <= PW'(xs * h00);
      m_q[1] <= PW'(ys * h01);
      m_q[2] <= PW'(xs * h10);
      m_q[3] <= PW'(ys * h11);
      m_q[4] <= PW'(xs * h20);
      m_q[5] <= PW'(ys * h21);
    end
  end

  // ---------------- stage 3: numerators and denominator ----------------
  logic signed [SW-1:0] numx_q, numy_q, den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q   <= s2_q;
      numx_q <= SW'(m_q[0]) + SW'(m_q[1]) + SW'(h02);
      numy_q <= SW'(m_q[2]) + SW'(m_q[3]) + SW'(h12);
      den_q  <= SW'(m_q[4]) + SW'(m_q[5]) + SW'(h22);
    end
  end

  // ---------------- stage 4: signs and magnitudes ----------------
  logic [SW-1:0]  nmx_q, nmy_q, dm_q;
  logic           negx, negy, den_zero;
  pwb_pkg::side_t s4_d;

  assign den_zero = (den_q == '0);
  assign negx     = (numx_q != '0) && (numx_q[SW-1] != den_q[SW-1]);
  assign negy     = (numy_q != '0) && (numy_q[SW-1] != den_q[SW-1]);

  // Side data with the no-sample flag filled in
  always_comb begin
    s4_d     = s3_q;
    s4_d.bad = den_zero || negx || negy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q     <= s4_d;
      nmx_q    <= numx_q[SW-1] ? SW'(-numx_q) : SW'(numx_q);
      nmy_q    <= numy_q[SW-1] ? SW'(-numy_q) : SW'(numy_q);
      dm_q     <= den_q[SW-1] ? SW'(-den_q) : SW'(den_q);
    end
  end

  // ---------------- dividers ----------------
  logic [QB-1:0] qx, qy;
  logic          ovfx, ovfy;

  pwb_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .nm_i  (nmx_q),
    .dm_i  (dm_q),
    .q_o   (qx),
    .ovf_o (ovfx)
  );

  pwb_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .nm_i  (nmy_q),
    .dm_i  (dm_q),
    .q_o   (qy),
    .ovf_o (ovfy)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= s4_q;
      for (int i = 1; i < NDIV; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // ---------------- stage 6: range check and bank addresses ----------------
  pwb_pkg::side_t sdl;
  logic [IB-1:0]  ix, iy;
  logic [LW-1:0]  wsat, hsat, lim;
  logic           fit_x, fit_y, ok;
  logic [AW-1:0]  raddr [4];
  logic [AW-1:0]  ld_addr;
  logic           ld_in;

  assign sdl = sd_q[NDIV-1];
  assign ix  = qx[QB-1:WF];
  assign iy  = qy[QB-1:WF];

  // Saturate the configured size to the store size
  assign wsat = (LW'(src_w_q) > LW'(pwb_pkg::SRC_MAX_WIDTH)) ?
                LW'(pwb_pkg::SRC_MAX_WIDTH) : LW'(src_w_q);
  assign hsat = (LW'(src_h_q) > LW'(pwb_pkg::SRC_MAX_HEIGHT)) ?
                LW'(pwb_pkg::SRC_MAX_HEIGHT) : LW'(src_h_q);
  assign lim   = trunc ? LW'(1) : LW'(2);
  assign fit_x = (LW'(ix) + lim) <= wsat;
  assign fit_y = (LW'(iy) + lim) <= hsat;
  assign ok    = sdl.cmd && !sdl.bad && !ovfx && !ovfy && fit_x && fit_y;

  // Each bank holds the neighbor whose column and row parity match it
  always_comb begin
    logic [IB-1:0] cx, cy;
    for (int b = 0; b < 4; b++) begin
      cx = (ix[0] == b[0]) ? ix : ix + IB'(1);
      cy = (iy[0] == b[1]) ? iy : iy + IB'(1);
      raddr[b] = AW'(AW'(cy[IB-1:1]) * AW'(pwb_pkg::BANK_COLS)) + AW'(cx[IB-1:1]);
    end
  end

  assign ld_in   = ({1'b0, sdl.pos_x} < (pwb_pkg::POS_W + 1)'(pwb_pkg::SRC_MAX_WIDTH)) &&
                   ({1'b0, sdl.pos_y} < (pwb_pkg::POS_W + 1)'(pwb_pkg::SRC_MAX_HEIGHT));
  assign ld_addr = AW'(AW'(sdl.pos_y[IB-1:1]) * AW'(pwb_pkg::BANK_COLS)) +
                   AW'(sdl.pos_x[IB-1:1]);

  pwb_pkg::side_t           s6_q;
  logic                     ok6_q;
  logic [WF-1:0]            wx6_q, wy6_q;
  logic                     px6_q, py6_q;
  logic [AW-1:0]            raddr6_q [4];
  logic [3:0]               we6_q;
  logic [AW-1:0]            waddr6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q     <= sdl;
      ok6_q    <= ok;
      wx6_q    <= qx[WF-1:0];
      wy6_q    <= qy[WF-1:0];
      px6_q    <= ix[0];
      py6_q    <= iy[0];
      for (int b = 0; b < 4; b++) begin
        raddr6_q[b] <= raddr[b];
        we6_q[b]    <= vd_q[NDIV-1] && !sdl.cmd && ld_in &&
                       (sdl.pos_x[0] == b[0]) && (sdl.pos_y[0] == b[1]);
      end
      waddr6_q <= ld_addr;
    end
  end

  // ---------------- source store: four banks ----------------
  logic [pwb_pkg::STORE_W-1:0] rdata [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pwb_ram #(
      .WIDTH (pwb_pkg::STORE_W),
      .DEPTH (pwb_pkg::BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (en && v6_q && we6_q[b]),
      .waddr_i (waddr6_q),
      .wdata_i ({s6_q.alpha, s6_q.pix}),
      .re_i    (en),
      .raddr_i (raddr6_q[b]),
      .rdata_o (rdata[b])
    );
  end

  // ---------------- stage 7: aligned with the store read ----------------
  pwb_pkg::side_t s7_q;
  logic           ok7_q;
  logic [WF-1:0]  wx7_q, wy7_q;
  logic           px7_q, py7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q  <= s6_q;
      ok7_q <= ok6_q;
      wx7_q <= wx6_q;
      wy7_q <= wy6_q;
      px7_q <= px6_q;
      py7_q <= py6_q;
    end
  end

  // Pick the four neighbors out of the banks
  logic [PXW-1:0] p00, p01, p10, p11, a00;
  logic [WF:0]    iwx;
  assign p00 = rdata[{py7_q, px7_q}][PXW-1:0];
  assign a00 = rdata[{py7_q, px7_q}][2*PXW-1:PXW];
  assign p01 = rdata[{py7_q, !px7_q}][PXW-1:0];
  assign p10 = rdata[{!py7_q, px7_q}][PXW-1:0];
  assign p11 = rdata[{!py7_q, !px7_q}][PXW-1:0];
  assign iwx = (WF + 1)'(1 << WF) - (WF + 1)'(wx7_q);

  // ---------------- stage 8: horizontal blend ----------------
  logic [pwb_pkg::TOP_W-1:0] top8_q, bot8_q;
  logic [PXW-1:0]            p8_q, a8_q, cur8_q;
  logic                      ok8_q, cmd8_q;
  logic [WF-1:0]             wy8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      top8_q <= pwb_pkg::TOP_W'(p00) * pwb_pkg::TOP_W'(iwx) +
                pwb_pkg::TOP_W'(p01) * pwb_pkg::TOP_W'(wx7_q);
      bot8_q <= pwb_pkg::TOP_W'(p10) * pwb_pkg::TOP_W'(iwx) +
                pwb_pkg::TOP_W'(p11) * pwb_pkg::TOP_W'(wx7_q);
      p8_q   <= p00;
      a8_q   <= a00;
      cur8_q <= s7_q.pix;
      ok8_q  <= ok7_q;
      cmd8_q <= s7_q.cmd;
      wy8_q  <= wy7_q;
    end
  end

  // ---------------- stage 9: vertical blend, sample select ----------------
  logic [WF:0]               iwy;
  logic [pwb_pkg::MIX_W-1:0] mix;
  logic [PXW-1:0]            smp9_q, a9_q, cur9_q;
  logic                      ok9_q, cmd9_q;

  assign iwy = (WF + 1)'(1 << WF) - (WF + 1)'(wy8_q);
  assign mix = pwb_pkg::MIX_W'(top8_q) * pwb_pkg::MIX_W'(iwy) +
               pwb_pkg::MIX_W'(bot8_q) * pwb_pkg::MIX_W'(wy8_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      smp9_q <= trunc ? p8_q : mix[2*WF +: PXW];
      a9_q   <= a8_q;
      cur9_q <= cur8_q;
      ok9_q  <= ok8_q;
      cmd9_q <= cmd8_q;
    end
  end

  // ---------------- stage 10: alpha mix ----------------
  logic [pwb_pkg::BL_W-1:0] mixa10_q;
  logic [PXW-1:0]           smp10_q, cur10_q;
  logic                     ok10_q, cmd10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mixa10_q <= pwb_pkg::BL_W'(smp9_q) * pwb_pkg::BL_W'(a9_q) +
                  pwb_pkg::BL_W'(cur9_q) * pwb_pkg::BL_W'(pwb_pkg::PIX_MAX - a9_q);
      smp10_q  <= smp9_q;
      cur10_q  <= cur9_q;
      ok10_q   <= ok9_q;
      cmd10_q  <= cmd9_q;
    end
  end

  assign last_v = v10_q && cmd10_q;

  // Divide by 255, truncated: (v + (v >> 8) + 1) >> 8 is exact for v up to 65534, above 255 * 255
  logic [pwb_pkg::BL_W:0] d255;
  logic [PXW-1:0]         res;
  assign d255 = (pwb_pkg::BL_W + 1)'(mixa10_q) +
                (pwb_pkg::BL_W + 1)'(mixa10_q >> PXW) + (pwb_pkg::BL_W + 1)'(1);
  assign res  = blend ? d255[PXW +: PXW] : smp10_q;

  // ---------------- output register ----------------
  logic [PXW-1:0] out_pixel_q;
  logic           written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= last_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && last_v) begin
      out_pixel_q <= ok10_q ? res : cur10_q;
      written_q   <= ok10_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign written_o   = written_q;

`ifndef SYNTHESIS
  // An empty output register never holds back the input
  a_free_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o) else $error("input stalled with empty output");

  // The pipe halts only behind a stalled result
  a_halt_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("pipe halted without cause");

  // A halted first stage keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en) |=> (v1_q && $stable(s1_q.pos_x) && $stable(s1_q.pix)))
    else $error("first stage word lost on halt");
`endif

endmodule

### bench/pwb_warp_checker.sv
module pwb_warp_checker
  import pwb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 cmd_i,
  input  logic [POS_W-1:0]     pos_x_i,
  input  logic [POS_W-1:0]     pos_y_i,
  input  logic [PIX_W-1:0]     pix_value_i,
  input  logic [PIX_W-1:0]     alpha_value_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [PIX_W-1:0]     out_pixel_i,
  input  logic                 written_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             wr;
  } warp_word_t;

  // shadow copy of the registers
  logic [CFG_W-1:0]  row0_q, row1_q, row2_q, shift01_q;
  logic [COEF_W-1:0] shift2_q;
  logic [MODE_W-1:0] mode_q;
  logic [DIM_W-1:0]  src_w_q, src_h_q;

  // pixel in 7..0, alpha in 15..8
  logic [STORE_W-1:0] src_mem [0:SRC_MAX_WIDTH*SRC_MAX_HEIGHT-1];

  warp_word_t pixel_expect_q [$];

  assign pending_o = pixel_expect_q.size();

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // floor(num * 2^WF / den); -1 for any negative quotient
  function automatic longint scaled_quot(longint num, longint den);
    longint unsigned nm, dm;
    if (num == 0) return 0;
    if ((num < 0) != (den < 0)) return -1;
    nm = (num < 0) ? longint'(-num) : num;
    dm = (den < 0) ? longint'(-den) : den;
    return longint'((nm << WF) / dm);
  endfunction

  function automatic logic [STORE_W-1:0] texel(longint ix, longint iy);
    return src_mem[iy * SRC_MAX_WIDTH + ix];
  endfunction

  function automatic warp_word_t warp_pixel(logic [POS_W-1:0] dx, logic [POS_W-1:0] dy,
                                            logic [PIX_W-1:0] cur);
    warp_word_t r;
    longint x, y, den, qx, qy, ix, iy, w, h, lim;
    longint unsigned wx, wy, one, top, bot;
    int unsigned smp, a;
    r.pixel = cur;
    r.wr = 1'b0;
    x = dx;
    y = dy;
    den = x * sx32(row2_q[63:32]) + y * sx32(row2_q[31:0]) + sx32(shift2_q);
    if (den == 0) return r;
    qx = scaled_quot(x * sx32(row0_q[63:32]) + y * sx32(row0_q[31:0])
                     + sx32(shift01_q[63:32]), den);
    qy = scaled_quot(x * sx32(row1_q[63:32]) + y * sx32(row1_q[31:0])
                     + sx32(shift01_q[31:0]), den);
    if (qx < 0 || qy < 0) return r;
    ix = qx >>> WF;
    iy = qy >>> WF;
    w = (src_w_q > SRC_MAX_WIDTH) ? SRC_MAX_WIDTH : src_w_q;
    h = (src_h_q > SRC_MAX_HEIGHT) ? SRC_MAX_HEIGHT : src_h_q;
    lim = mode_q[MODE_TRUNC_BIT] ? 1 : 2;
    if (ix > w - lim || iy > h - lim) return r;
    a = texel(ix, iy) >> PIX_W;
    if (mode_q[MODE_TRUNC_BIT]) begin
      smp = texel(ix, iy) & 8'hFF;
    end else begin
      one = longint'(1) << WF;
      wx = qx & (one - 1);
      wy = qy & (one - 1);
      top = (texel(ix, iy) & 8'hFF) * (one - wx) + (texel(ix + 1, iy) & 8'hFF) * wx;
      bot = (texel(ix, iy + 1) & 8'hFF) * (one - wx)
            + (texel(ix + 1, iy + 1) & 8'hFF) * wx;
      smp = ((top * (one - wy) + bot * wy) >> (2 * WF)) & 8'hFF;
    end
    if (mode_q[MODE_BLEND_BIT])
      r.pixel = (smp * a + cur * (PIX_MAX - a)) / PIX_MAX;
    else
      r.pixel = smp;
    r.wr = 1'b1;
    return r;
  endfunction

  // sample at the falling edge; everything seen here is taken at the next rising edge
  always @(negedge clk_i) begin
    warp_word_t got, exp_w;
    if (!rst_ni) begin
      row0_q    = '0;
      row1_q    = '0;
      row2_q    = '0;
      shift01_q = '0;
      shift2_q  = 32'd16777216;
      mode_q    = '0;
      src_w_q   = 9'd256;
      src_h_q   = 9'd256;
      fail_count_o = 0;
      checked_o = 0;
      pixel_expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ROW0_LIN: row0_q = cfg_wdata_i;
          CFG_ROW1_LIN: row1_q = cfg_wdata_i;
          CFG_ROW2_LIN: row2_q = cfg_wdata_i;
          CFG_SHIFT01:  shift01_q = cfg_wdata_i;
          CFG_SHIFT2:   shift2_q = cfg_wdata_i[COEF_W-1:0];
          CFG_MODE:     mode_q = cfg_wdata_i[MODE_W-1:0];
          CFG_SRC_W:    src_w_q = cfg_wdata_i[DIM_W-1:0];
          CFG_SRC_H:    src_h_q = cfg_wdata_i[DIM_W-1:0];
          default: ;
        endcase
      end
      // output word: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got.pixel = out_pixel_i;
        got.wr = written_i;
        checked_o++;
        if (pixel_expect_q.size() == 0) begin
          $display("%0t: unexpected word pixel=%0d written=%0b", $time, got.pixel, got.wr);
          fail_count_o++;
        end else begin
          exp_w = pixel_expect_q.pop_front();
          if (got.pixel !== exp_w.pixel) begin
            $display("%0t: out_pixel expected %0d got %0d", $time, exp_w.pixel, got.pixel);
            fail_count_o++;
          end
          if (got.wr !== exp_w.wr) begin
            $display("%0t: written expected %0b got %0b", $time, exp_w.wr, got.wr);
            fail_count_o++;
          end
        end
      end
      // input word: store a load, predict a warp
      if (in_valid_i && !in_stall_i) begin
        if (!cmd_i) begin
          if (pos_x_i < SRC_MAX_WIDTH && pos_y_i < SRC_MAX_HEIGHT)
            src_mem[pos_y_i * SRC_MAX_WIDTH + pos_x_i] = {alpha_value_i, pix_value_i};
        end else begin
          pixel_expect_q.push_back(warp_pixel(pos_x_i, pos_y_i, pix_value_i));
        end
      end
    end
  end

endmodule

### bench/perspective_warp_bilinear_tb.sv
module perspective_warp_bilinear_tb;
  import pwb_pkg::*;

  localparam int ONE_Q = 1 << 24;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = 1'b0;
  logic [POS_W-1:0]     pos_x = '0;
  logic [POS_W-1:0]     pos_y = '0;
  logic [PIX_W-1:0]     pix_value = '0;
  logic [PIX_W-1:0]     alpha_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic                 written;
  int                   fail_count, pending, checked;

  bit quiet = 1'b0;
  bit in_gaps = 1'b1;
  int stall_left = 0;
  int words_sent = 0;
  bit loaded [0:SRC_MAX_WIDTH*SRC_MAX_HEIGHT-1];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  perspective_warp_bilinear dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .pos_x_i(pos_x), .pos_y_i(pos_y),
    .pix_value_i(pix_value), .alpha_value_i(alpha_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_pixel_o(out_pixel), .written_o(written)
  );

  pwb_warp_checker chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .pos_x_i(pos_x), .pos_y_i(pos_y),
    .pix_value_i(pix_value), .alpha_value_i(alpha_value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_pixel_i(out_pixel), .written_i(written),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // receiver stalls in random bursts, never while quiet
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom % 6 == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [31:0] rnd_q(int lo, int hi);
    return 32'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  // one word over the input channel; called at a rising edge
  task automatic send_word(bit c, int x, int y, int p, int a);
    bit taken;
    if (!quiet && in_gaps && $urandom % 5 == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cmd <= c;
    pos_x <= POS_W'(x);
    pos_y <= POS_W'(y);
    pix_value <= PIX_W'(p);
    alpha_value <= PIX_W'(a);
    in_valid <= 1'b1;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
    words_sent++;
    if (!c && x < SRC_MAX_WIDTH && y < SRC_MAX_HEIGHT) loaded[y * SRC_MAX_WIDTH + x] = 1'b1;
  endtask

  task automatic warp_at(int x, int y);
    send_word(1'b1, x, y, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // drain the pipe, reprogram, then make sure every readable texel is loaded
  task automatic setup(int w, int h, int mode, logic [63:0] r0, logic [63:0] r1,
                       logic [63:0] r2, logic [63:0] s01, logic [31:0] s2);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(CFG_ROW0_LIN, r0);
    write_reg(CFG_ROW1_LIN, r1);
    write_reg(CFG_ROW2_LIN, r2);
    write_reg(CFG_SHIFT01, s01);
    write_reg(CFG_SHIFT2, {32'd0, s2});
    write_reg(CFG_MODE, 64'(mode));
    write_reg(CFG_SRC_W, 64'(w));
    write_reg(CFG_SRC_H, 64'(h));
    in_gaps = ($urandom % 4 != 0);
    for (int iy = 0; iy < h; iy++)
      for (int ix = 0; ix < w; ix++)
        if (!loaded[iy * SRC_MAX_WIDTH + ix])
          send_word(1'b0, ix, iy, $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // mostly warps near the origin, some far out, some reloads
  task automatic traffic(int n, int w, int h, int span);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom % 100;
      if (r < 12)
        send_word(1'b0, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      else if (r < 15)
        send_word(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      if ($urandom % 8 == 0) warp_at($urandom_range(0, 4095), $urandom_range(0, 4095));
      else warp_at($urandom_range(0, span), $urandom_range(0, span));
    end
  endtask

  task automatic random_phase(int n);
    int w, h, sg;
    logic [31:0] h00, h11;
    w = $urandom_range(2, 16);
    h = $urandom_range(2, 16);
    sg = ($urandom % 5 == 0) ? -1 : 1;
    h00 = rnd_q(ONE_Q / 4, 3 * ONE_Q / 2);
    h11 = rnd_q(ONE_Q / 4, 3 * ONE_Q / 2);
    setup(w, h, $urandom_range(0, 3),
          {h00, rnd_q(-ONE_Q / 4, ONE_Q / 4)},
          {rnd_q(-ONE_Q / 4, ONE_Q / 4), h11},
          ($urandom % 3 == 0) ? 64'd0 : {rnd_q(-65536, 65536), rnd_q(-65536, 65536)},
          {rnd_q(-2 * ONE_Q, 2 * ONE_Q), rnd_q(-2 * ONE_Q, 2 * ONE_Q)},
          32'(sg * int'(rnd_q(ONE_Q / 2, 3 * ONE_Q / 2))));
    traffic(n, w, h, 2 * (w > h ? w : h) + 4);
  endtask

  initial begin
    logic [63:0] ident0, ident1;
    ident0 = {32'(ONE_Q), 32'd0};
    ident1 = {32'd0, 32'(ONE_Q)};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity map over an 8x8 source, corners and edges in each mode
    setup(8, 8, 0, ident0, ident1, 64'd0, 64'd0, 32'(ONE_Q));
    warp_at(0, 0);
    warp_at(6, 6);
    warp_at(7, 7);
    warp_at(3, 5);
    warp_at(4095, 4095);
    send_word(1'b0, 4095, 4095, 255, 255);
    setup(8, 8, 1, ident0, ident1, 64'd0, 64'd0, 32'(ONE_Q));
    warp_at(7, 7);
    warp_at(8, 0);
    warp_at(0, 8);
    setup(8, 8, 2, ident0, ident1, 64'd0, 64'd0, 32'(ONE_Q));
    warp_at(2, 2);
    warp_at(6, 1);
    setup(8, 8, 3, ident0, ident1, 64'd0, 64'd0, 32'(ONE_Q));
    warp_at(1, 4);
    warp_at(7, 0);
    // zero denominator
    setup(8, 8, 0, ident0, ident1, 64'd0, 64'd0, 32'd0);
    warp_at(0, 0);
    warp_at(5, 5);
    // negative source coordinate
    setup(8, 8, 1, ident0, ident1, 64'd0, {-32'(ONE_Q), 32'd0}, 32'(ONE_Q));
    warp_at(0, 3);
    warp_at(3, 3);
    // half scale: fractional weights
    setup(8, 8, 0, {32'(ONE_Q / 2), 32'd0}, {32'd0, 32'(ONE_Q / 3)}, 64'd0, 64'd0,
          32'(ONE_Q));
    warp_at(5, 3);
    warp_at(13, 20);

    for (int p = 0; p < 4; p++) random_phase(36);

    // widest source, then a tall narrow one
    setup(256, 2, $urandom_range(0, 3), ident0, {32'd0, 32'(ONE_Q / 2)}, 64'd0,
          64'd0, 32'(ONE_Q));
    traffic(40, 256, 2, 260);
    setup(2, 64, $urandom_range(0, 3), {32'd0, 32'd0}, ident1, 64'd0,
          {32'(ONE_Q / 3), 32'd0}, 32'(ONE_Q));
    traffic(40, 2, 64, 70);

    // full-range coefficients, extreme h22
    setup(2, 2, 2, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
          {$urandom, $urandom}, 32'h8000_0000);
    traffic(30, 2, 2, 4095);
    setup(2, 2, 1, {$urandom, $urandom}, {$urandom, $urandom}, 64'd0,
          {$urandom, $urandom}, 32'h7FFF_FFFF);
    traffic(30, 2, 2, 4095);

    // last stretch with no idling on either side
    quiet = 1'b1;
    random_phase(60);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d words (loads and warps), checked %0d warp results", words_sent,
             checked);
    $display("Covered all four modes, source sizes from 2 to 256, zero and negative maps");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
